@@ hdl/json_string_unescape_utf8_defines.svh @@
// Assertion helpers used by the top-level RTL.
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define JSU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jsu: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jsu: next-cycle check failed");

`endif

@@ hdl/jsu_pkg.sv @@
package jsu_pkg;

   localparam int MAX_RUN             = 6;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5c;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;

   typedef enum logic [1:0] {
      STATUS_BYTE      = 2'd0,
      STATUS_DONE      = 2'd1,
      STATUS_MALFORMED = 2'd2
   } status_type;

   // Results caused by one input byte; all but the last carry STATUS_BYTE.
   typedef struct packed {
      logic [MAX_RUN-1:0][7:0] bytes;
      logic [2:0]              count;
      status_type              last_status;
   } run_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      len;
   } utf8_type;

   function automatic utf8_type utf8_encode(input logic [20:0] cp);
      utf8_type r;
      r = '0;
      if (cp <= 21'h7f) begin
         r.bytes[0] = cp[7:0];
         r.len      = 3'd1;
      end else if (cp <= 21'h7ff) begin
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
         r.len      = 3'd2;
      end else if (cp <= 21'hffff) begin
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
         r.len      = 3'd3;
      end else begin
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
         r.len      = 3'd4;
      end
      return r;
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         r = {1'b1, 4'(b[3:0] + 4'd9)};
      end
      return r;
   endfunction

   function automatic logic [7:0] esc_map(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         8'h62:   r = 8'h08;
         8'h66:   r = 8'h0c;
         8'h6e:   r = 8'h0a;
         8'h72:   r = 8'h0d;
         8'h74:   r = 8'h09;
         default: r = b;
      endcase
      return r;
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == CHAR_SPACE) || (b >= 8'h09 && b <= 8'h0d);
   endfunction

endpackage

@@ hdl/jsu_if.sv @@
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;

   modport source (output valid, output in_byte, output end_of_text, input ready);
   modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] status;
   logic       last_of_run;

   modport source (output valid, output out_byte, output status, output last_of_run,
                   input ready);
   modport sink   (input valid, input out_byte, input status, input last_of_run,
                   output ready);
endinterface

@@ hdl/jsu_front.sv @@
module jsu_front (
   input  logic              clock,
   input  logic              reset,
   jsu_req_if.sink           req,
   input  logic              q_full,
   output logic              push,
   output jsu_pkg::run_type  run
);
   import jsu_pkg::*;

   typedef enum logic [2:0] {
      MODE_QUOTE, MODE_TEXT, MODE_ESC, MODE_HEX_HI,
      MODE_PAIR_BS, MODE_PAIR_U, MODE_HEX_LO, MODE_FAIL
   } mode_type;

   typedef enum logic [1:0] {B_NONE, B_CP, B_ONE} bkind_type;

   mode_type    mode_ff, mode_in;
   logic [1:0]  digit_ff, digit_in;
   logic [15:0] first_ff, first_in;
   logic [15:0] second_ff, second_in;
   logic        closed_ff, closed_in;

   logic        accept;
   logic        a_en;
   logic [15:0] a_cp;
   bkind_type   b_kind;
   logic [20:0] b_cp;
   logic [7:0]  b_byte;
   status_type  b_stat;
   logic [4:0]  hexv;
   logic [15:0] unit;
   utf8_type    enc_a, enc_b;
   logic [2:0]  len_a, len_b;
   logic [7:0]  b;

   assign b         = req.in_byte;
   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;
   assign hexv      = hex_digit(b);

   always_comb begin
      mode_in   = mode_ff;
      digit_in  = digit_ff;
      first_in  = first_ff;
      second_in = second_ff;
      closed_in = closed_ff;
      a_en      = 1'b0;
      a_cp      = first_ff;
      b_kind    = B_NONE;
      b_cp      = '0;
      b_byte    = '0;
      b_stat    = STATUS_BYTE;
      unit      = '0;

      if (!closed_ff) begin
         case (mode_ff)
            MODE_QUOTE: begin
               if (b == CHAR_QUOTE) begin
                  mode_in = MODE_TEXT;
               end else if (!is_space(b)) begin
                  b_kind  = B_ONE;
                  b_stat  = STATUS_MALFORMED;
                  mode_in = MODE_FAIL;
               end
            end
            MODE_TEXT, MODE_PAIR_BS: begin
               if (mode_ff == MODE_PAIR_BS && b != CHAR_BSLASH) begin
                  a_en = 1'b1;  // high surrogate left unpaired
               end
               if (mode_ff == MODE_PAIR_BS && b == CHAR_BSLASH) begin
                  mode_in = MODE_PAIR_U;
               end else if (b == CHAR_QUOTE) begin
                  b_kind    = B_ONE;
                  b_stat    = STATUS_DONE;
                  closed_in = 1'b1;
                  mode_in   = MODE_TEXT;
               end else if (b == CHAR_BSLASH) begin
                  mode_in = MODE_ESC;
               end else begin
                  b_kind  = B_ONE;
                  b_byte  = b;
                  mode_in = MODE_TEXT;
               end
            end
            MODE_ESC: begin
               if (b == CHAR_U) begin
                  mode_in  = MODE_HEX_HI;
                  digit_in = 2'd0;
                  first_in = '0;
               end else begin
                  b_kind  = B_ONE;
                  b_byte  = esc_map(b);
                  mode_in = MODE_TEXT;
               end
            end
            MODE_PAIR_U: begin
               if (b == CHAR_U) begin
                  mode_in   = MODE_HEX_LO;
                  digit_in  = 2'd0;
                  second_in = '0;
               end else begin
                  a_en    = 1'b1;
                  b_kind  = B_ONE;
                  b_byte  = esc_map(b);
                  mode_in = MODE_TEXT;
               end
            end
            MODE_HEX_HI: begin
               if (!hexv[4]) begin
                  b_kind  = B_ONE;
                  b_stat  = STATUS_MALFORMED;
                  mode_in = MODE_FAIL;
               end else begin
                  unit     = {first_ff[11:0], hexv[3:0]};
                  first_in = unit;
                  if (digit_ff == 2'd3) begin
                     digit_in = 2'd0;
                     if (unit[15:10] == 6'b110110) begin
                        mode_in = MODE_PAIR_BS;
                     end else begin
                        b_kind  = B_CP;
                        b_cp    = {5'd0, unit};
                        mode_in = MODE_TEXT;
                     end
                  end else begin
                     digit_in = digit_ff + 2'd1;
                  end
               end
            end
            MODE_HEX_LO: begin
               if (!hexv[4]) begin
                  b_kind  = B_ONE;
                  b_stat  = STATUS_MALFORMED;
                  mode_in = MODE_FAIL;
               end else begin
                  unit      = {second_ff[11:0], hexv[3:0]};
                  second_in = unit;
                  if (digit_ff != 2'd3) begin
                     digit_in = digit_ff + 2'd1;
                  end else begin
                     digit_in = 2'd0;
                     if (unit[15:10] == 6'b110111) begin
                        b_kind  = B_CP;
                        b_cp    = 21'h10000 + {1'b0, first_ff[9:0], unit[9:0]};
                        mode_in = MODE_TEXT;
                     end else begin
                        a_en = 1'b1;
                        if (unit[15:10] == 6'b110110) begin
                           first_in = unit;
                           mode_in  = MODE_PAIR_BS;
                        end else begin
                           b_kind  = B_CP;
                           b_cp    = {5'd0, unit};
                           mode_in = MODE_TEXT;
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (req.end_of_text) begin
         if (!closed_in && mode_in != MODE_FAIL) begin
            a_en   = 1'b0;
            b_kind = B_ONE;
            b_byte = '0;
            b_stat = STATUS_MALFORMED;
         end
         mode_in   = MODE_QUOTE;
         digit_in  = 2'd0;
         first_in  = '0;
         second_in = '0;
         closed_in = 1'b0;
      end
   end

   // Splice the unpaired-unit bytes ahead of this byte's own output.
   always_comb begin
      logic [2:0] k_idx;
      logic [2:0] off;
      enc_a = utf8_encode({5'd0, a_cp});
      len_a = a_en ? enc_a.len : 3'd0;
      if (b_kind == B_ONE) begin
         enc_b          = '0;
         enc_b.bytes[0] = b_byte;
         enc_b.len      = 3'd1;
      end else begin
         enc_b = utf8_encode(b_cp);
      end
      len_b = (b_kind == B_NONE) ? 3'd0 : enc_b.len;
      for (int k = 0; k < MAX_RUN; k++) begin
         k_idx = 3'(k);
         off   = k_idx - len_a;
         run.bytes[k] = (k_idx < len_a) ? enc_a.bytes[k_idx[1:0]] : enc_b.bytes[off[1:0]];
      end
      run.count       = len_a + len_b;
      run.last_status = (b_kind == B_ONE) ? b_stat : STATUS_BYTE;
   end

   assign push = accept && (run.count != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_QUOTE;
         digit_ff  <= 2'd0;
         first_ff  <= '0;
         second_ff <= '0;
         closed_ff <= 1'b0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         digit_ff  <= digit_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         closed_ff <= closed_in;
      end
   end

endmodule

@@ hdl/jsu_queue.sv @@
module jsu_queue #(
   parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jsu_pkg::run_type  push_run,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output jsu_pkg::run_type  head
);
   import jsu_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   run_type          mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hdl/jsu_back.sv @@
module jsu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  jsu_pkg::run_type  head,
   output logic              pop,
   jsu_rsp_if.source         rsp
);
   import jsu_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] byte_ff;
   status_type status_ff;
   logic       last_ff;
   logic [2:0] idx_ff, idx_in;
   logic       load;
   logic       at_last;

   assign load    = head_valid && (!out_valid_ff || rsp.ready);
   assign at_last = (idx_ff == head.count - 3'd1);
   assign pop     = load && at_last;

   always_comb begin
      out_valid_in = out_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         out_valid_in = 1'b1;
         idx_in       = at_last ? 3'd0 : idx_ff + 3'd1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= head.bytes[idx_ff];
         status_ff <= at_last ? head.last_status : STATUS_BYTE;
         last_ff   <= at_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.out_byte    = byte_ff;
   assign rsp.status      = status_ff;
   assign rsp.last_of_run = last_ff;

endmodule

@@ hdl/json_string_unescape_utf8.sv @@
// Streaming JSON string decoder. Feed the bytes of a JSON value starting just
// after the colon, one transfer per byte, with end_of_text set on the last
// byte of the text. Leading whitespace is skipped, an opening quote is
// required, and the string body comes out as UTF-8 bytes (status 0). Escapes
// \" \\ \/ \b \f \n \r \t and \uXXXX are decoded, other escaped bytes pass
// through unchanged, and a \u high/low surrogate pair becomes one 4-byte
// sequence; an unpaired surrogate is sent as its 3-byte form. The closing
// quote yields one status 1 transfer; junk before the quote, a bad hex digit
// or end_of_text on a still-open string yields one status 2 transfer. After
// either, bytes produce nothing until end_of_text, which returns the block
// to its start state. last_of_run marks the final transfer caused by a byte.
// Throughput: one input byte per cycle. Each byte produces 0 to 6 output
// transfers, and the output port moves one per cycle while rsp ready is
// high. The input side only stalls when the QUEUE_DEPTH-entry run queue
// between the parser and the output stage fills. A byte's run is written
// into the run queue and then into the output register. No clearing pass
// after reset.
`include "json_string_unescape_utf8_defines.svh"

module json_string_unescape_utf8 #(
   parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   jsu_req_if.sink    req_chan,
   jsu_rsp_if.source  rsp_chan
);
   import jsu_pkg::*;

   // parser -> run queue
   logic    q_push;
   run_type q_push_run;
   logic    q_full;

   // run queue -> output serializer
   logic    q_pop;
   logic    q_head_valid;
   run_type q_head;

   // Front: whitespace/quote/escape parsing, one byte per cycle while the queue
   // is not full, builds the whole run of result bytes for that byte.
   jsu_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .q_full (q_full),
      .push   (q_push),
      .run    (q_push_run)
   );

   // Short queue of runs; lets the parser keep going while the output waits.
   jsu_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_run   (q_push_run),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head       (q_head)
   );

   // Back: walks the head run one byte per transfer into the output register.
   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head       (q_head),
      .pop        (q_pop),
      .rsp        (rsp_chan)
   );

   // Completion and malformed reports always close their run.
   `JSU_ASSERT_NOW(a_status_closes_run, clock, reset,
      rsp_chan.valid && (rsp_chan.status != STATUS_BYTE), rsp_chan.last_of_run)

   // Completion and malformed reports carry a zero byte.
   `JSU_ASSERT_NOW(a_status_byte_zero, clock, reset,
      rsp_chan.valid && (rsp_chan.status != STATUS_BYTE), rsp_chan.out_byte == 8'd0)

   // Queued runs are never empty and never longer than the worst case.
   `JSU_ASSERT_NOW(a_run_len, clock, reset,
      q_head_valid, (q_head.count != 3'd0) && (q_head.count <= 3'(MAX_RUN)))

   // A push into a full queue would drop a run.
   `JSU_ASSERT_NEXT(a_no_overflow, clock, reset,
      q_full && !q_pop, !q_push || q_full)

endmodule
